/* hw/rtl/hhp_pkg.sv */
// Shared types, constants and register map of the heading-hold PID block.
package hhp_pkg;

  // Field widths
  localparam int unsigned HeadW   = 15;
  localparam int unsigned RateW   = 16;
  localparam int unsigned TickW   = 16;
  localparam int unsigned FacW    = 13;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned CorrW   = 16;
  localparam int unsigned IntegW  = 16;
  localparam int unsigned DerivW  = 27;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 5;

  // Datapath widths
  localparam int unsigned MulAW   = 28;
  localparam int unsigned MulBW   = 17;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned FacProdW = ProdW + FacW + 1;
  localparam int unsigned DvdW    = 32;
  localparam int unsigned DivCntW = 5;

  // Fixed-point constants, Q4.12
  localparam int signed   Pi      = 12868;
  localparam int signed   TwoPi   = 25736;
  localparam int unsigned Damp    = 410;
  localparam int unsigned MinTick = 66;

  // Register reset values
  localparam logic [CfgW-1:0] GainPRst    = 15'd614;
  localparam logic [CfgW-1:0] GainIRst    = 15'd41;
  localparam logic [CfgW-1:0] GainDRst    = 15'd82;
  localparam logic [CfgW-1:0] IntLimRst   = 15'd4096;
  localparam logic [CfgW-1:0] CorrLimRst  = 15'd1229;

  typedef enum logic [2:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_INT_LIM  = 3'd3,
    REG_CORR_LIM = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] gain_p;
    logic [CfgW-1:0] gain_i;
    logic [CfgW-1:0] gain_d;
    logic [CfgW-1:0] integral_limit;
    logic [CfgW-1:0] correction_limit;
  } cfg_t;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_PROD_INT = 12'b0000_0000_0010,
    S_INT      = 12'b0000_0000_0100,
    S_DIV      = 12'b0000_0000_1000,
    S_DERIV    = 12'b0000_0001_0000,
    S_MUL_P    = 12'b0000_0010_0000,
    S_MUL_I    = 12'b0000_0100_0000,
    S_MUL_D    = 12'b0000_1000_0000,
    S_MUL_R    = 12'b0001_0000_0000,
    S_ACC_R    = 12'b0010_0000_0000,
    S_FAC      = 12'b0100_0000_0000,
    S_OUT      = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    MUL_TICK = 3'd0,
    MUL_P    = 3'd1,
    MUL_I    = 3'd2,
    MUL_D    = 3'd3,
    MUL_R    = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_CLR  = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     int_upd;
    logic     div_step;
    logic     deriv_upd;
    acc_op_e  acc_op;
    logic     fac_en;
    logic     out_load;
  } cmd_t;

endpackage

/* hw/rtl/hhp_ifs.sv */
// Valid/ready channel interfaces for control ticks and corrections.
interface hhp_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [hhp_pkg::HeadW-1:0]          measured_heading;
  logic signed [hhp_pkg::HeadW-1:0]          target_heading;
  logic signed [hhp_pkg::RateW-1:0]          yaw_rate;
  logic        [hhp_pkg::TickW-1:0]          tick_interval;
  logic        [hhp_pkg::FacW-1:0]           speed_factor;
  logic                                      clear_state;

  modport source (
    output valid, measured_heading, target_heading, yaw_rate, tick_interval,
           speed_factor, clear_state,
    input  ready
  );
  modport sink (
    input  valid, measured_heading, target_heading, yaw_rate, tick_interval,
           speed_factor, clear_state,
    output ready
  );
endinterface

interface hhp_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [hhp_pkg::CorrW-1:0]          correction;
  logic                                      limited;

  modport source (output valid, correction, limited, input ready);
  modport sink   (input valid, correction, limited, output ready);
endinterface

/* hw/rtl/hhp_regs.sv */
// APB configuration register file: gains and limits.
module hhp_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hhp_pkg::AddrW-1:0]   paddr,
  input  logic [hhp_pkg::DataW-1:0]   pwdata,
  output logic [hhp_pkg::DataW-1:0]   prdata,
  output hhp_pkg::cfg_t               cfg_o
);

  hhp_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [2:0]    idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        hhp_pkg::REG_GAIN_P:   cfg_d.gain_p           = pwdata[hhp_pkg::CfgW-1:0];
        hhp_pkg::REG_GAIN_I:   cfg_d.gain_i           = pwdata[hhp_pkg::CfgW-1:0];
        hhp_pkg::REG_GAIN_D:   cfg_d.gain_d           = pwdata[hhp_pkg::CfgW-1:0];
        hhp_pkg::REG_INT_LIM:  cfg_d.integral_limit   = pwdata[hhp_pkg::CfgW-1:0];
        hhp_pkg::REG_CORR_LIM: cfg_d.correction_limit = pwdata[hhp_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p           <= hhp_pkg::GainPRst;
      cfg_q.gain_i           <= hhp_pkg::GainIRst;
      cfg_q.gain_d           <= hhp_pkg::GainDRst;
      cfg_q.integral_limit   <= hhp_pkg::IntLimRst;
      cfg_q.correction_limit <= hhp_pkg::CorrLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      hhp_pkg::REG_GAIN_P:   prdata[hhp_pkg::CfgW-1:0] = cfg_q.gain_p;
      hhp_pkg::REG_GAIN_I:   prdata[hhp_pkg::CfgW-1:0] = cfg_q.gain_i;
      hhp_pkg::REG_GAIN_D:   prdata[hhp_pkg::CfgW-1:0] = cfg_q.gain_d;
      hhp_pkg::REG_INT_LIM:  prdata[hhp_pkg::CfgW-1:0] = cfg_q.integral_limit;
      hhp_pkg::REG_CORR_LIM: prdata[hhp_pkg::CfgW-1:0] = cfg_q.correction_limit;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/hhp_ctrl.sv */
// Sequencer: steps one tick through integral, divide, gain products and output.
module hhp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hhp_pkg::cmd_t cmd_o
);

  hhp_pkg::state_e              state_q, state_d;
  logic [hhp_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.mul_sel = hhp_pkg::MUL_TICK;
    cmd_o.acc_op  = hhp_pkg::ACC_HOLD;
    in_ready_o  = 1'b0;

    // drop the word once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      hhp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = hhp_pkg::S_PROD_INT;
        end
      end
      hhp_pkg::S_PROD_INT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hhp_pkg::MUL_TICK;
        state_d       = hhp_pkg::S_INT;
      end
      hhp_pkg::S_INT: begin
        cmd_o.int_upd = 1'b1;
        cnt_d         = '0;
        state_d       = hhp_pkg::S_DIV;
      end
      hhp_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = hhp_pkg::S_DERIV;
        end
      end
      hhp_pkg::S_DERIV: begin
        cmd_o.deriv_upd = 1'b1;
        state_d         = hhp_pkg::S_MUL_P;
      end
      hhp_pkg::S_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hhp_pkg::MUL_P;
        cmd_o.acc_op  = hhp_pkg::ACC_CLR;
        state_d       = hhp_pkg::S_MUL_I;
      end
      hhp_pkg::S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hhp_pkg::MUL_I;
        cmd_o.acc_op  = hhp_pkg::ACC_ADD;
        state_d       = hhp_pkg::S_MUL_D;
      end
      hhp_pkg::S_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hhp_pkg::MUL_D;
        cmd_o.acc_op  = hhp_pkg::ACC_ADD;
        state_d       = hhp_pkg::S_MUL_R;
      end
      hhp_pkg::S_MUL_R: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hhp_pkg::MUL_R;
        cmd_o.acc_op  = hhp_pkg::ACC_ADD;
        state_d       = hhp_pkg::S_ACC_R;
      end
      hhp_pkg::S_ACC_R: begin
        // damping enters with negative sign
        cmd_o.acc_op = hhp_pkg::ACC_SUB;
        state_d      = hhp_pkg::S_FAC;
      end
      hhp_pkg::S_FAC: begin
        cmd_o.fac_en = 1'b1;
        state_d      = hhp_pkg::S_OUT;
      end
      hhp_pkg::S_OUT: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = hhp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hhp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hhp_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/hhp_dp.sv */
// Datapath: angle wrap, integral, restoring divider, shared gain multiplier.
module hhp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hhp_pkg::cmd_t                       cmd_i,
  input  hhp_pkg::cfg_t                       cfg_i,
  input  logic signed [hhp_pkg::HeadW-1:0]    measured_heading_i,
  input  logic signed [hhp_pkg::HeadW-1:0]    target_heading_i,
  input  logic signed [hhp_pkg::RateW-1:0]    yaw_rate_i,
  input  logic        [hhp_pkg::TickW-1:0]    tick_interval_i,
  input  logic        [hhp_pkg::FacW-1:0]     speed_factor_i,
  input  logic                                clear_state_i,
  output logic signed [hhp_pkg::CorrW-1:0]    correction_o,
  output logic                                limited_o
);

  // Persistent controller state
  logic signed [hhp_pkg::IntegW-1:0]  integ_q, integ_d;
  logic signed [hhp_pkg::HeadW-1:0]   prev_q, prev_d;

  // Per-tick payload
  logic signed [hhp_pkg::HeadW-1:0]   err_q;
  logic signed [hhp_pkg::RateW-1:0]   rate_q;
  logic        [hhp_pkg::TickW-1:0]   tick_q;
  logic        [hhp_pkg::FacW-1:0]    fac_q;
  logic                               neg_q;
  logic        [hhp_pkg::DvdW-1:0]    dvd_q;
  logic        [hhp_pkg::TickW-1:0]   rem_q;
  logic signed [hhp_pkg::DerivW-1:0]  deriv_q;
  logic signed [hhp_pkg::ProdW-1:0]   prod_q;
  logic signed [hhp_pkg::ProdW-1:0]   acc_q;
  logic signed [hhp_pkg::FacProdW-1:0] fprod_q;
  logic signed [hhp_pkg::CorrW-1:0]   corr_q;
  logic                               lim_q;

  // Angle wrap
  logic signed [16:0] raw_err;
  logic signed [16:0] wrap_err;
  logic signed [hhp_pkg::HeadW-1:0] err_w;
  logic signed [hhp_pkg::HeadW-1:0] prev_eff;
  logic signed [15:0] derr;
  logic        [15:0] derr_mag;

  assign raw_err = {{2{measured_heading_i[hhp_pkg::HeadW-1]}}, measured_heading_i}
                 - {{2{target_heading_i[hhp_pkg::HeadW-1]}}, target_heading_i};

  always_comb begin
    if (raw_err >= 17'(hhp_pkg::Pi)) begin
      wrap_err = raw_err - 17'(hhp_pkg::TwoPi);
    end else if (raw_err < -17'(hhp_pkg::Pi)) begin
      wrap_err = raw_err + 17'(hhp_pkg::TwoPi);
    end else begin
      wrap_err = raw_err;
    end
  end

  assign err_w    = wrap_err[hhp_pkg::HeadW-1:0];
  assign prev_eff = clear_state_i ? '0 : prev_q;
  assign derr     = {err_w[hhp_pkg::HeadW-1], err_w} - {prev_eff[hhp_pkg::HeadW-1], prev_eff};
  assign derr_mag = derr[15] ? 16'(-derr) : derr;

  // Integral update with round-to-nearest of e*dt and symmetric clamp
  logic signed [hhp_pkg::ProdW-1:0] int_rnd;
  logic signed [16:0] int_step;
  logic signed [17:0] int_sum;
  logic signed [17:0] int_lim;

  assign int_rnd  = prod_q + hhp_pkg::ProdW'(32768);
  assign int_step = int_rnd[32:16];
  assign int_sum  = {{2{integ_q[hhp_pkg::IntegW-1]}}, integ_q}
                  + {int_step[16], int_step};
  assign int_lim  = $signed({3'b000, cfg_i.integral_limit});

  // Restoring divider step: one quotient bit per cycle
  logic [hhp_pkg::TickW:0]   rem_sh;
  logic [hhp_pkg::TickW+1:0] trial;
  logic                      qbit;

  assign rem_sh = {rem_q, dvd_q[hhp_pkg::DvdW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, tick_q};
  assign qbit   = !trial[hhp_pkg::TickW+1];

  logic signed [hhp_pkg::DerivW-1:0] quo_s;
  assign quo_s = $signed({1'b0, dvd_q[hhp_pkg::DerivW-2:0]});

  // Shared gain multiplier
  logic signed [hhp_pkg::MulAW-1:0] mul_a;
  logic signed [hhp_pkg::MulBW-1:0] mul_b;

  always_comb begin
    case (cmd_i.mul_sel)
      hhp_pkg::MUL_TICK: begin
        mul_a = {{(hhp_pkg::MulAW-hhp_pkg::HeadW){err_q[hhp_pkg::HeadW-1]}}, err_q};
        mul_b = {1'b0, tick_q};
      end
      hhp_pkg::MUL_P: begin
        mul_a = {{(hhp_pkg::MulAW-hhp_pkg::HeadW){err_q[hhp_pkg::HeadW-1]}}, err_q};
        mul_b = {2'b00, cfg_i.gain_p};
      end
      hhp_pkg::MUL_I: begin
        mul_a = {{(hhp_pkg::MulAW-hhp_pkg::IntegW){integ_q[hhp_pkg::IntegW-1]}}, integ_q};
        mul_b = {2'b00, cfg_i.gain_i};
      end
      hhp_pkg::MUL_D: begin
        mul_a = {deriv_q[hhp_pkg::DerivW-1], deriv_q};
        mul_b = {2'b00, cfg_i.gain_d};
      end
      hhp_pkg::MUL_R: begin
        mul_a = {{(hhp_pkg::MulAW-hhp_pkg::RateW){rate_q[hhp_pkg::RateW-1]}}, rate_q};
        mul_b = hhp_pkg::MulBW'(hhp_pkg::Damp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Final speed-factor scale and output clamp
  logic signed [hhp_pkg::FacProdW-1:0] fac_rnd;
  logic signed [34:0] total;
  logic signed [34:0] corr_lim;

  assign fac_rnd  = fprod_q + hhp_pkg::FacProdW'(64'd8388608);
  assign total    = fac_rnd[58:24];
  assign corr_lim = $signed({20'd0, cfg_i.correction_limit});

  always_comb begin
    integ_d = integ_q;
    prev_d  = prev_q;
    if (cmd_i.load && clear_state_i) begin
      integ_d = '0;
      prev_d  = '0;
    end
    if (cmd_i.int_upd) begin
      if (int_sum > int_lim) begin
        integ_d = int_lim[hhp_pkg::IntegW-1:0];
      end else if (int_sum < -int_lim) begin
        integ_d = 16'(-int_lim);
      end else begin
        integ_d = int_sum[hhp_pkg::IntegW-1:0];
      end
    end
    if (cmd_i.deriv_upd) begin
      prev_d = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      integ_q <= integ_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q  <= err_w;
      rate_q <= yaw_rate_i;
      tick_q <= tick_interval_i;
      fac_q  <= speed_factor_i;
      neg_q  <= derr[15];
      dvd_q  <= {derr_mag, 16'h0000};
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? trial[hhp_pkg::TickW-1:0] : rem_sh[hhp_pkg::TickW-1:0];
      dvd_q <= {dvd_q[hhp_pkg::DvdW-2:0], qbit};
    end
    if (cmd_i.deriv_upd) begin
      if (tick_q >= hhp_pkg::TickW'(hhp_pkg::MinTick)) begin
        deriv_q <= neg_q ? -quo_s : quo_s;
      end else begin
        deriv_q <= '0;
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.acc_op)
      hhp_pkg::ACC_CLR:  acc_q <= '0;
      hhp_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
      hhp_pkg::ACC_SUB:  acc_q <= acc_q - prod_q;
      default: ;
    endcase
    if (cmd_i.fac_en) begin
      fprod_q <= acc_q * $signed({1'b0, fac_q});
    end
    if (cmd_i.out_load) begin
      if (total > corr_lim) begin
        corr_q <= corr_lim[hhp_pkg::CorrW-1:0];
        lim_q  <= 1'b1;
      end else if (total < -corr_lim) begin
        corr_q <= 16'(-corr_lim);
        lim_q  <= 1'b1;
      end else begin
        corr_q <= total[hhp_pkg::CorrW-1:0];
        lim_q  <= 1'b0;
      end
    end
  end

  assign correction_o = corr_q;
  assign limited_o    = lim_q;

endmodule

/* hw/rtl/heading_hold_pid.sv */
// Heading-hold PID controller top level: register file, sequencer and datapath.
//
//  channel   dir   handshake        word contents
//  in_i      in    valid/ready      measured/target heading, yaw rate, tick, factor, clear
//  out_o     out   valid/ready      correction, limited
//  apb       in    psel/penable     gains and limits at byte address 4*index
//
// A tick is carried through to its output load before the next tick is taken:
// the sequencer accepts a new tick only in idle, which it reenters after the output load.
// The 32-step restoring divider for the derivative dominates the processing of each tick.
// Reset clears the integral and the stored error and loads the default gains.
// A result waiting on out_o does not block acceptance of the next tick; only the
// output load of that next tick waits for the slot to drain.
module heading_hold_pid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hhp_in_if.sink                      in_i,
  hhp_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hhp_pkg::AddrW-1:0]   paddr,
  input  logic [hhp_pkg::DataW-1:0]   pwdata,
  output logic [hhp_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  hhp_pkg::cfg_t cfg;
  hhp_pkg::cmd_t cmd;

  assign pready = 1'b1;

  hhp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  hhp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  hhp_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .measured_heading_i (in_i.measured_heading),
    .target_heading_i   (in_i.target_heading),
    .yaw_rate_i         (in_i.yaw_rate),
    .tick_interval_i    (in_i.tick_interval),
    .speed_factor_i     (in_i.speed_factor),
    .clear_state_i      (in_i.clear_state),
    .correction_o       (out_o.correction),
    .limited_o          (out_o.limited)
  );

endmodule

/* tb/heading_hold_pid_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for heading_hold_pid: directed ticks, random ticks, APB config phases.
module heading_hold_pid_tb;
  import hhp_pkg::*;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned TicksPerPhase = 250;
  localparam int unsigned MaxGap        = 14;
  localparam int unsigned DrainCycles   = 50;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned WdLimit       = 2000;
  localparam logic [2:0]  NoRegIdx      = 3'd7;

  typedef struct {
    logic signed [HeadW-1:0] meas;
    logic signed [HeadW-1:0] targ;
    logic signed [RateW-1:0] rate;
    logic        [TickW-1:0] dt;
    logic        [FacW-1:0]  fac;
    logic                    clr;
  } tick_t;

  typedef struct {
    logic signed [CorrW-1:0] corr;
    logic                    lim;
  } corr_t;

  typedef struct {
    tick_t t;
    bit    typed;
    corr_t want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  hhp_in_if  tick_if ();
  hhp_out_if corr_if ();

  heading_hold_pid dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_if),
    .out_o   (corr_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: registers, integral and stored error
  cfg_t        pid_cfg;
  longint      integ_q;
  longint      prev_err_q;

  corr_t       corr_expect_q [$];
  dir_row_t    dir_tbl [$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cnt = 0;
  bit          idle_on;
  bit          hold_off_req;

  always #10 clk_i = ~clk_i;

  function automatic corr_t predict_correction(tick_t t);
    longint err, integ, deriv, acc, total, res, ilim, clim;
    corr_t  r;
    if (t.clr) begin
      integ_q    = 0;
      prev_err_q = 0;
    end
    err = longint'(t.meas) - longint'(t.targ);
    while (err >= Pi) err -= TwoPi;
    while (err < -Pi) err += TwoPi;

    ilim  = longint'(pid_cfg.integral_limit);
    integ = integ_q + ((err * longint'(t.dt) + 32768) >>> 16);
    if (integ > ilim) integ = ilim;
    else if (integ < -ilim) integ = -ilim;
    integ_q = integ;

    // short ticks give no derivative; quotient truncates toward zero
    if (t.dt >= MinTick) deriv = ((err - prev_err_q) * 65536) / longint'(t.dt);
    else deriv = 0;
    prev_err_q = err;

    acc = longint'(pid_cfg.gain_p) * err + longint'(pid_cfg.gain_i) * integ
        + longint'(pid_cfg.gain_d) * deriv - longint'(Damp) * longint'(t.rate);
    total = (acc * longint'(t.fac) + (longint'(1) <<< 23)) >>> 24;

    clim = longint'(pid_cfg.correction_limit);
    if (total > clim) res = clim;
    else if (total < -clim) res = -clim;
    else res = total;
    r.corr = CorrW'(res);
    r.lim  = (res != total);
    return r;
  endfunction

  function automatic dir_row_t mk_row(int meas, int targ, int rate, int dt, int fac, bit clr,
                                      bit typed = 1'b0, int corr = 0, bit lim = 1'b0);
    dir_row_t row;
    row.t.meas    = HeadW'(meas);
    row.t.targ    = HeadW'(targ);
    row.t.rate    = RateW'(rate);
    row.t.dt      = TickW'(dt);
    row.t.fac     = FacW'(fac);
    row.t.clr     = clr;
    row.typed     = typed;
    row.want.corr = CorrW'(corr);
    row.want.lim  = lim;
    return row;
  endfunction

  // Leaves psel high after the access; the caller drops it once the accesses are done
  task automatic apb_write(input logic [2:0] idx, input logic [CfgW-1:0] val,
                           input logic [DataW-CfgW-1:0] junk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_GAIN_P:   pid_cfg.gain_p           = val;
      REG_GAIN_I:   pid_cfg.gain_i           = val;
      REG_GAIN_D:   pid_cfg.gain_d           = val;
      REG_INT_LIM:  pid_cfg.integral_limit   = val;
      REG_CORR_LIM: pid_cfg.correction_limit = val;
      default: ;
    endcase
  endtask

  task automatic apb_read(input logic [2:0] idx);
    logic [CfgW-1:0] want;
    case (idx)
      REG_GAIN_P:  want = pid_cfg.gain_p;
      REG_GAIN_I:  want = pid_cfg.gain_i;
      REG_GAIN_D:  want = pid_cfg.gain_d;
      REG_INT_LIM: want = pid_cfg.integral_limit;
      default:     want = pid_cfg.correction_limit;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CfgW-1:0] !== want) begin
      $display("%0t: register %0d readback: expected %0d, got %0d",
               $time, idx, want, prdata[CfgW-1:0]);
      mismatch_cnt++;
    end
  endtask

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_if.valid            <= 1'b1;
    tick_if.measured_heading <= t.meas;
    tick_if.target_heading   <= t.targ;
    tick_if.yaw_rate         <= t.rate;
    tick_if.tick_interval    <= t.dt;
    tick_if.speed_factor     <= t.fac;
    tick_if.clear_state      <= t.clr;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  initial begin
    logic [CfgW-1:0]       vals [5];
    logic [DataW-CfgW-1:0] junk;
    logic signed [HeadW-1:0] last_targ;
    tick_t       t;
    corr_t       want;
    int unsigned n_rand;

    rst_ni                   <= 1'b0;
    tick_if.valid            <= 1'b0;
    tick_if.measured_heading <= '0;
    tick_if.target_heading   <= '0;
    tick_if.yaw_rate         <= '0;
    tick_if.tick_interval    <= '0;
    tick_if.speed_factor     <= '0;
    tick_if.clear_state      <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    pid_cfg    = '{GainPRst, GainIRst, GainDRst, IntLimRst, CorrLimRst};
    integ_q    = 0;
    prev_err_q = 0;
    idle_on    = 1'b1;
    hold_off_req = 1'b0;
    last_targ  = '0;

    // zero error keeps the state at zero, so these rows read off directly
    dir_tbl.push_back(mk_row(0, 0, 0, 0, 4096, 0, 1, 0, 0));
    dir_tbl.push_back(mk_row(0, 0, -32768, 0, 4096, 0, 1, 1229, 1));
    dir_tbl.push_back(mk_row(0, 0, 32767, 0, 4096, 0, 1, -1229, 1));
    dir_tbl.push_back(mk_row(0, 0, 32767, 0, 0, 0, 1, 0, 0));
    dir_tbl.push_back(mk_row(0, 0, 0, 0, 8191, 0, 1, 0, 0));
    // wrap across +-pi and from outside the heading range
    dir_tbl.push_back(mk_row(12867, -12868, 0, 1310, 4096, 0));
    dir_tbl.push_back(mk_row(-12868, 12867, 0, 1310, 4096, 0));
    dir_tbl.push_back(mk_row(16383, -16384, 0, 1310, 4096, 0));
    dir_tbl.push_back(mk_row(-16384, 16383, 0, 1310, 4096, 0));
    dir_tbl.push_back(mk_row(12868, 0, 100, 1310, 4096, 0));
    dir_tbl.push_back(mk_row(-12868, 0, -100, 1310, 4096, 0));
    // derivative threshold and tick extremes
    dir_tbl.push_back(mk_row(3000, 0, 0, 65, 4096, 0));
    dir_tbl.push_back(mk_row(-3000, 0, 0, 66, 4096, 0));
    dir_tbl.push_back(mk_row(3000, -3000, 0, 65535, 4096, 0));
    dir_tbl.push_back(mk_row(12867, 0, 0, 65535, 8191, 0));
    dir_tbl.push_back(mk_row(12867, 0, 0, 65535, 8191, 0));
    dir_tbl.push_back(mk_row(-12868, 0, 0, 0, 4096, 0));
    dir_tbl.push_back(mk_row(-12868, 0, 32767, 65535, 8191, 0));
    dir_tbl.push_back(mk_row(-12868, 0, -32768, 65535, 8191, 0));
    dir_tbl.push_back(mk_row(5000, 1000, 0, 1310, 4096, 1));
    dir_tbl.push_back(mk_row(0, 0, 0, 1310, 4096, 1));
    dir_tbl.push_back(mk_row(0, 16383, -1, 1, 1, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_on = !(ph == 3 || ph == 6);
      if (ph != 0) begin
        case (ph)
          1: vals = '{default: 15'h7FFF};
          2: vals = '{GainPRst, GainIRst, GainDRst, 15'd0, 15'd0};
          3: vals = '{15'd0, 15'd0, 15'd0, 15'h7FFF, 15'h7FFF};
          4: vals = '{15'h7FFF, 15'd0, 15'd0, 15'd200, 15'h7FFF};
          default: begin
            foreach (vals[k])
              vals[k] = CfgW'((ph == 7) ? $urandom_range(0, 32767) : $urandom_range(0, 2048));
          end
        endcase
        for (int k = 0; k < 5; k++) begin
          junk = (ph % 2 == 1) ? (DataW-CfgW)'($urandom()) : '0;
          apb_write(3'(k), vals[k], junk);
        end
        // writes past the last register must leave the map untouched
        if (ph == 4) apb_write(NoRegIdx, CfgW'($urandom()), '0);
      end
      for (int k = 0; k < 5; k++) apb_read(3'(k));
      psel    <= 1'b0;
      penable <= 1'b0;

      n_rand = TicksPerPhase;
      if (ph == 0) begin
        foreach (dir_tbl[k]) begin
          send_tick(dir_tbl[k].t);
          want = predict_correction(dir_tbl[k].t);
          if (dir_tbl[k].typed) want = dir_tbl[k].want;
          corr_expect_q.push_back(want);
        end
        n_rand = TicksPerPhase - dir_tbl.size();
      end

      if (ph == 1) hold_off_req = 1'b1;

      for (int unsigned i = 0; i < n_rand; i++) begin
        if ($urandom_range(0, 4) != 0) t.meas = HeadW'($urandom_range(0, TwoPi - 1) - Pi);
        else t.meas = HeadW'($urandom());
        // hold the target for a while so the integral can build up
        if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 4) != 0) last_targ = HeadW'($urandom_range(0, TwoPi - 1) - Pi);
          else last_targ = HeadW'($urandom());
        end
        t.targ = last_targ;
        if ($urandom_range(0, 2) != 0) t.rate = RateW'($urandom_range(0, 4095) - 2048);
        else t.rate = RateW'($urandom());
        case ($urandom_range(0, 9))
          0, 1:          t.dt = TickW'($urandom_range(0, MinTick));
          2, 3, 4, 5, 6: t.dt = TickW'($urandom_range(800, 2000));
          default:       t.dt = TickW'($urandom());
        endcase
        if ($urandom_range(0, 2) != 0) t.fac = FacW'($urandom_range(0, 4096));
        else t.fac = FacW'($urandom());
        t.clr = ($urandom_range(0, 15) == 0);
        send_tick(t);
        corr_expect_q.push_back(predict_correction(t));
      end
      tick_if.valid <= 1'b0;

      // drain before touching the registers again
      wait (corr_expect_q.size() == 0);
      repeat (DrainCycles) @(posedge clk_i);
    end

    if (corr_expect_q.size() != 0) begin
      $display("%0t: %0d corrections never arrived", $time, corr_expect_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off to back up the input
  initial begin
    int unsigned stall;
    corr_t       want;
    corr_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, MaxGap) : 0;
      if (hold_off_req) begin
        corr_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        corr_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      corr_if.ready <= 1'b1;
      do @(posedge clk_i); while (!corr_if.valid);
      if (corr_expect_q.size() == 0) begin
        $display("%0t: unexpected word: correction %0d limited %0b",
                 $time, corr_if.correction, corr_if.limited);
        mismatch_cnt++;
      end else begin
        want = corr_expect_q.pop_front();
        if (corr_if.correction !== want.corr || corr_if.limited !== want.lim) begin
          $display("%0t: mismatch: expected correction %0d limited %0b, got %0d %0b",
                   $time, want.corr, want.lim, corr_if.correction, corr_if.limited);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no traffic on any port
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (tick_if.valid && tick_if.ready) ||
        (corr_if.valid && corr_if.ready)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= WdLimit) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
